[rtl/sscp_pkg.sv]
`timescale 1ns / 1ps
package sscp_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int PARAM_BITS = 16;
  localparam int PARAM_W    = PARAM_BITS + 1;
  localparam int GAP_W      = 34;
  localparam int SQ_W       = 66;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_BITS;

  // register map
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [31:0] THR_RESET = 32'd1;

endpackage

[rtl/sscp_div.sv]
`timescale 1ns / 1ps
module sscp_div #(
  parameter int W  = 104,
  parameter int TW = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic signed [W-1:0]             num,
  input  logic signed [W-1:0]             den,
  input  logic [TW-1:0]                   in_tag,
  output logic                            out_valid,
  output logic [sscp_pkg::PARAM_W-1:0]    quo,
  output logic [TW-1:0]                   out_tag
);
  import sscp_pkg::*;

  localparam int NS = PARAM_BITS;
  localparam logic signed [W-1:0] ZERO = '0;

  logic                  vld_r  [0:NS];
  logic [W-1:0]          rem_r  [0:NS];
  logic [W-1:0]          den_r  [0:NS];
  logic [PARAM_BITS-1:0] q_r    [0:NS];
  logic                  zero_r [0:NS];
  logic                  one_r  [0:NS];
  logic [TW-1:0]         tag_r  [0:NS];

  // entry: classify saturating cases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      zero_r[0] <= (num <= ZERO);
      one_r[0]  <= (num >= den);
      tag_r[0]  <= in_tag;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [W:0] sh;
    logic [W:0] diff;
    logic       ge;

    assign sh   = {rem_r[k-1], 1'b0};
    assign diff = sh - {1'b0, den_r[k-1]};
    assign ge   = !diff[W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? diff[W-1:0] : sh[W-1:0];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][PARAM_BITS-2:0], ge};
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
        tag_r[k]  <= tag_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[NS];
  assign out_tag   = tag_r[NS];
  assign quo = zero_r[NS] ? '0 : (one_r[NS] ? PARAM_ONE : {1'b0, q_r[NS]});

endmodule

[rtl/sscp_sqrt.sv]
`timescale 1ns / 1ps
module sscp_sqrt #(
  parameter int VW = 66,
  parameter int TW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [VW-1:0]     val,
  input  logic [TW-1:0]     in_tag,
  output logic              out_valid,
  output logic [VW/2-1:0]   root,
  output logic [TW-1:0]     out_tag
);
  localparam int NB = VW / 2;
  localparam int RW = NB + 3;

  logic          vld_r  [0:NB];
  logic [VW-1:0] val_r  [0:NB];
  logic [RW-1:0] rem_r  [0:NB];
  logic [NB-1:0] root_r [0:NB];
  logic [TW-1:0] tag_r  [0:NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r[0]  <= val;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      tag_r[0]  <= in_tag;
    end
  end

  // one result bit per stage, two radicand bits at a time
  for (genvar k = 1; k <= NB; k++) begin : g_step
    logic [RW-1:0] remsh;
    logic [RW-1:0] trial;
    logic          ge;

    assign remsh = {rem_r[k-1][RW-3:0], val_r[k-1][2*(NB-k)+1 -: 2]};
    assign trial = RW'({root_r[k-1], 2'b01});
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        val_r[k]  <= val_r[k-1];
        rem_r[k]  <= ge ? (remsh - trial) : remsh;
        root_r[k] <= {root_r[k-1][NB-2:0], ge};
        tag_r[k]  <= tag_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[NB];
  assign root      = root_r[NB];
  assign out_tag   = tag_r[NB];

endmodule

[rtl/segment_segment_closest_points.sv]
`timescale 1ns / 1ps
// Channel  | ports                          | transfer when
// in_      | in_valid/in_stall + 12 coords  | in_valid && !in_stall
// out_     | out_valid/out_stall + 9 fields | out_valid && !out_stall
// cfg_     | APB write/read, threshold at 0 | psel && penable && pwrite
//
// One segment pair enters per cycle unless the output stalls. The two
// 17-stage parameter dividers and the 34-stage square root make up most of the pipeline.
// Reset (rst_n low, synchronous) empties the pipeline and sets the threshold to 1.
// A stalled output holds the whole pipeline in place; in_stall follows it.
module segment_segment_closest_points #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_first_start_x,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_first_start_y,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_first_start_z,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_first_end_x,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_first_end_y,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_first_end_z,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_second_start_x,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_second_start_y,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_second_start_z,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_second_end_x,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_second_end_y,
  input  logic signed [sscp_pkg::COORD_W-1:0]  in_second_end_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sscp_pkg::PARAM_W-1:0]         out_param_first,
  output logic [sscp_pkg::PARAM_W-1:0]         out_param_second,
  output logic signed [sscp_pkg::COORD_W-1:0]  out_near_first_x,
  output logic signed [sscp_pkg::COORD_W-1:0]  out_near_first_y,
  output logic signed [sscp_pkg::COORD_W-1:0]  out_near_first_z,
  output logic signed [sscp_pkg::COORD_W-1:0]  out_near_second_x,
  output logic signed [sscp_pkg::COORD_W-1:0]  out_near_second_y,
  output logic signed [sscp_pkg::COORD_W-1:0]  out_near_second_z,
  output logic [sscp_pkg::GAP_W-1:0]           out_gap_length,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [2:0]                           cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import sscp_pkg::*;

  // dot products fit in DW signed bits after the fraction shift
  localparam int DW = 68 - COORD_FRAC_BITS;
  localparam int PW = 2 * DW;
  localparam int W1 = PW + 1;
  localparam int W2 = DW + 20;
  // split of the wide cross products into halves
  localparam int ML = DW / 2;
  localparam int MH = DW - ML;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] p0;
    logic [2:0][COORD_W-1:0] q0;
    logic [2:0][DIFF_W-1:0]  d1;
    logic [2:0][DIFF_W-1:0]  d2;
  } geo_t;

  typedef struct packed {
    geo_t                 g;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] e;
    logic signed [DW-1:0] f;
    logic                 pa;
    logic                 pe;
  } cas_t;

  typedef struct packed {
    geo_t               g;
    logic               dst_t;
    logic [PARAM_W-1:0] keep;
  } sel_t;

  typedef struct packed {
    logic [PARAM_W-1:0]      s;
    logic [PARAM_W-1:0]      t;
    logic [2:0][COORD_W-1:0] c1;
    logic [2:0][COORD_W-1:0] c2;
  } pts_t;

  // ---------------------------------------------------------------- config
  logic [31:0] thr_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_THRESHOLD)) begin
      thr_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_THRESHOLD) ? thr_r : '0;

  logic signed [DW-1:0] thr_dw;
  logic signed [W1-1:0] thr_w1;
  assign thr_dw = DW'(thr_r);
  assign thr_w1 = W1'(thr_r);

  // -------------------------------------------------------- flow control
  // the whole pipe moves together; the output register frees it when taken
  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;

  logic v1_r, v2_r, v3_r, v4_r, v4p_r, v6_r, v7_r, v8_r, v9_r, v10_r;

  // ------------------------------------------------- S1: edge vectors
  logic signed [COORD_W-1:0] ps [3];
  logic signed [COORD_W-1:0] pe_in [3];
  logic signed [COORD_W-1:0] qs [3];
  logic signed [COORD_W-1:0] qe [3];
  geo_t                      g1_r;
  logic [2:0][DIFF_W-1:0]    r1_r;

  assign ps[0] = in_first_start_x;  assign ps[1] = in_first_start_y;
  assign ps[2] = in_first_start_z;
  assign pe_in[0] = in_first_end_x; assign pe_in[1] = in_first_end_y;
  assign pe_in[2] = in_first_end_z;
  assign qs[0] = in_second_start_x; assign qs[1] = in_second_start_y;
  assign qs[2] = in_second_start_z;
  assign qe[0] = in_second_end_x;   assign qe[1] = in_second_end_y;
  assign qe[2] = in_second_end_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        g1_r.p0[i] <= ps[i];
        g1_r.q0[i] <= qs[i];
        g1_r.d1[i] <= DIFF_W'(pe_in[i]) - DIFF_W'(ps[i]);
        g1_r.d2[i] <= DIFF_W'(qe[i]) - DIFF_W'(qs[i]);
        r1_r[i]    <= DIFF_W'(ps[i]) - DIFF_W'(qs[i]);
      end
    end
  end

  // ------------------------------------------- S2: coordinate products
  geo_t                       g2_r;
  logic signed [2*DIFF_W-1:0] pa_r [3];
  logic signed [2*DIFF_W-1:0] pb_r [3];
  logic signed [2*DIFF_W-1:0] pc_r [3];
  logic signed [2*DIFF_W-1:0] pe_r [3];
  logic signed [2*DIFF_W-1:0] pf_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_r <= g1_r;
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= $signed(g1_r.d1[i]) * $signed(g1_r.d1[i]);
        pb_r[i] <= $signed(g1_r.d1[i]) * $signed(g1_r.d2[i]);
        pc_r[i] <= $signed(g1_r.d1[i]) * $signed(r1_r[i]);
        pe_r[i] <= $signed(g1_r.d2[i]) * $signed(g1_r.d2[i]);
        pf_r[i] <= $signed(g1_r.d2[i]) * $signed(r1_r[i]);
      end
    end
  end

  // ------------------------------------------- S3: dot products, floored
  logic signed [67:0] sa, sb, sc, se, sf;
  cas_t               c3_r;

  assign sa = 68'(pa_r[0]) + 68'(pa_r[1]) + 68'(pa_r[2]);
  assign sb = 68'(pb_r[0]) + 68'(pb_r[1]) + 68'(pb_r[2]);
  assign sc = 68'(pc_r[0]) + 68'(pc_r[1]) + 68'(pc_r[2]);
  assign se = 68'(pe_r[0]) + 68'(pe_r[1]) + 68'(pe_r[2]);
  assign sf = 68'(pf_r[0]) + 68'(pf_r[1]) + 68'(pf_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r.g  <= g2_r;
      c3_r.a  <= DW'(sa >>> COORD_FRAC_BITS);
      c3_r.b  <= DW'(sb >>> COORD_FRAC_BITS);
      c3_r.c  <= DW'(sc >>> COORD_FRAC_BITS);
      c3_r.e  <= DW'(se >>> COORD_FRAC_BITS);
      c3_r.f  <= DW'(sf >>> COORD_FRAC_BITS);
      c3_r.pa <= 1'b0;
      c3_r.pe <= 1'b0;
    end
  end

  // ------------------ S4: degenerate flags, partial cross products
  // products in order: a*e, b*b, b*f, c*e
  cas_t                    c4_r;
  logic signed [DW-1:0]    mx [4];
  logic signed [DW-1:0]    my [4];
  logic signed [2*MH-1:0]  mhh_r [4];
  logic signed [MH+ML:0]   mhl_r [4];
  logic signed [MH+ML:0]   mlh_r [4];
  logic [2*ML-1:0]         mll_r [4];

  assign mx[0] = c3_r.a;  assign my[0] = c3_r.e;
  assign mx[1] = c3_r.b;  assign my[1] = c3_r.b;
  assign mx[2] = c3_r.b;  assign my[2] = c3_r.f;
  assign mx[3] = c3_r.c;  assign my[3] = c3_r.e;

  always_ff @(posedge clk) begin
    if (adv) begin
      c4_r.g  <= c3_r.g;
      c4_r.a  <= c3_r.a;
      c4_r.b  <= c3_r.b;
      c4_r.c  <= c3_r.c;
      c4_r.e  <= c3_r.e;
      c4_r.f  <= c3_r.f;
      c4_r.pa <= (c3_r.a <= thr_dw);
      c4_r.pe <= (c3_r.e <= thr_dw);
      for (int k = 0; k < 4; k++) begin
        mhh_r[k] <= $signed(mx[k][DW-1:ML]) * $signed(my[k][DW-1:ML]);
        mhl_r[k] <= $signed(mx[k][DW-1:ML]) * $signed({1'b0, my[k][ML-1:0]});
        mlh_r[k] <= $signed({1'b0, mx[k][ML-1:0]}) * $signed(my[k][DW-1:ML]);
        mll_r[k] <= mx[k][ML-1:0] * my[k][ML-1:0];
      end
    end
  end

  // ------------------------------ S4p: combine the partial products
  cas_t                 c4p_r;
  logic signed [PW-1:0] prod_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      c4p_r <= c4_r;
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= (PW'(mhh_r[k]) << (2*ML)) + ((PW'(mhl_r[k]) + PW'(mlh_r[k])) << ML)
                     + PW'(mll_r[k]);
      end
    end
  end

  // --------------------- S5: first parameter s = (bf - ce) / denom
  logic signed [W1-1:0] denom, snum, num1, den1;
  logic                 gen_ok;

  assign denom  = W1'(prod_r[0]) - W1'(prod_r[1]);
  assign snum   = W1'(prod_r[2]) - W1'(prod_r[3]);
  // parallel or degenerate: force s to zero through a zero numerator
  assign gen_ok = !c4p_r.pa && !c4p_r.pe && (denom > thr_w1);
  assign num1   = gen_ok ? snum : '0;
  assign den1   = gen_ok ? denom : W1'(1);

  logic               d1_valid;
  logic [PARAM_W-1:0] s1;
  cas_t               c5;

  sscp_div #(.W(W1), .TW($bits(cas_t))) u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v4p_r),
    .num       (num1),
    .den       (den1),
    .in_tag    (c4p_r),
    .out_valid (d1_valid),
    .quo       (s1),
    .out_tag   (c5)
  );

  // ---------------------------- S6: t numerator b*s + f, denominator e
  logic signed [DW+17:0] bs;
  cas_t                  c6_r;
  logic signed [W2-1:0]  tnum_r, tden_r;
  logic [PARAM_W-1:0]    s6_r;

  assign bs = c5.b * $signed({1'b0, s1});

  always_ff @(posedge clk) begin
    if (adv) begin
      c6_r   <= c5;
      s6_r   <= s1;
      tnum_r <= W2'(bs) + (W2'(c5.f) <<< PARAM_BITS);
      tden_r <= W2'(c5.e) <<< PARAM_BITS;
    end
  end

  // ---------------- S7: pick the second division and where it lands
  logic signed [W2-1:0] negc, bmc, aw;
  logic signed [W2-1:0] num2_nxt, den2_nxt;
  logic signed [W2-1:0] num2_r, den2_r;
  sel_t                 sel_nxt, sel7_r;

  assign negc = -W2'(c6_r.c);
  assign bmc  = W2'(c6_r.b) - W2'(c6_r.c);
  assign aw   = W2'(c6_r.a);

  always_comb begin
    sel_nxt.g     = c6_r.g;
    sel_nxt.dst_t = 1'b0;
    sel_nxt.keep  = '0;
    num2_nxt      = negc;
    den2_nxt      = aw;
    if (c6_r.pa && c6_r.pe) begin
      // both points: s = t = 0
      num2_nxt = '0;
      den2_nxt = W2'(1);
    end else if (c6_r.pa) begin
      num2_nxt      = W2'(c6_r.f);
      den2_nxt      = W2'(c6_r.e);
      sel_nxt.dst_t = 1'b1;
    end else if (c6_r.pe) begin
      // second segment is a point: s = -c / a
    end else if (tnum_r < 0) begin
      // t clamps to 0, redo s from -c / a
    end else if (tnum_r > tden_r) begin
      num2_nxt     = bmc;
      sel_nxt.keep = PARAM_ONE;
    end else begin
      num2_nxt      = tnum_r;
      den2_nxt      = tden_r;
      sel_nxt.dst_t = 1'b1;
      sel_nxt.keep  = s6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num2_r <= num2_nxt;
      den2_r <= den2_nxt;
      sel7_r <= sel_nxt;
    end
  end

  logic               d2_valid;
  logic [PARAM_W-1:0] q2;
  sel_t               sel8;

  sscp_div #(.W(W2), .TW($bits(sel_t))) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v7_r),
    .num       (num2_r),
    .den       (den2_r),
    .in_tag    (sel7_r),
    .out_valid (d2_valid),
    .quo       (q2),
    .out_tag   (sel8)
  );

  // ----------------------------- S8: scale edges by the parameters
  logic [PARAM_W-1:0]          s8, t8;
  logic [PARAM_W-1:0]          s8_r, t8_r;
  logic [2:0][COORD_W-1:0]     p0_8_r, q0_8_r;
  logic signed [DIFF_W+PARAM_W:0] ms_r [3];
  logic signed [DIFF_W+PARAM_W:0] mt_r [3];

  assign s8 = sel8.dst_t ? sel8.keep : q2;
  assign t8 = sel8.dst_t ? q2 : sel8.keep;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_r   <= s8;
      t8_r   <= t8;
      p0_8_r <= sel8.g.p0;
      q0_8_r <= sel8.g.q0;
      for (int i = 0; i < 3; i++) begin
        ms_r[i] <= $signed(sel8.g.d1[i]) * $signed({1'b0, s8});
        mt_r[i] <= $signed(sel8.g.d2[i]) * $signed({1'b0, t8});
      end
    end
  end

  // ------------------------------------------- S9: closest points
  pts_t              pts9_r;
  logic signed [33:0] c1w [3];
  logic signed [33:0] c2w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1w[i] = 34'($signed(p0_8_r[i])) + 34'(ms_r[i] >>> PARAM_BITS);
      c2w[i] = 34'($signed(q0_8_r[i])) + 34'(mt_r[i] >>> PARAM_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts9_r.s <= s8_r;
      pts9_r.t <= t8_r;
      for (int i = 0; i < 3; i++) begin
        pts9_r.c1[i] <= c1w[i][COORD_W-1:0];
        pts9_r.c2[i] <= c2w[i][COORD_W-1:0];
      end
    end
  end

  // ------------------------------------------- S10: squared gaps
  pts_t                    pts10_r;
  logic signed [DIFF_W-1:0] gd [3];
  logic [2*DIFF_W-2:0]      sq_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gd[i] = DIFF_W'($signed(pts9_r.c1[i])) - DIFF_W'($signed(pts9_r.c2[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts10_r <= pts9_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (2*DIFF_W-1)'(gd[i] * gd[i]);
      end
    end
  end

  // ------------------------------------------- distance root
  logic [SQ_W-1:0]   gap_sq;
  logic              rt_valid;
  logic [SQ_W/2-1:0] rt;
  pts_t              pts_out;

  assign gap_sq = SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);

  sscp_sqrt #(.VW(SQ_W), .TW($bits(pts_t))) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v10_r),
    .val       (gap_sq),
    .in_tag    (pts10_r),
    .out_valid (rt_valid),
    .root      (rt),
    .out_tag   (pts_out)
  );

  // ---------------------------------------------- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v4p_r       <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v4p_r       <= v4_r;
      v6_r        <= d1_valid;
      v7_r        <= v6_r;
      v8_r        <= d2_valid;
      v9_r        <= v8_r;
      v10_r       <= v9_r;
      out_valid_r <= rt_valid;
    end
  end

  // ---------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_param_first   <= pts_out.s;
      out_param_second  <= pts_out.t;
      out_near_first_x  <= pts_out.c1[0];
      out_near_first_y  <= pts_out.c1[1];
      out_near_first_z  <= pts_out.c1[2];
      out_near_second_x <= pts_out.c2[0];
      out_near_second_y <= pts_out.c2[1];
      out_near_second_z <= pts_out.c2[2];
      out_gap_length    <= GAP_W'(rt);
    end
  end

  // ---------------------------------------------- checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  a_param_first_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_param_first <= PARAM_ONE))
    else $error("s out of range");

  a_param_second_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_param_second <= PARAM_ONE))
    else $error("t out of range");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && v10_r) |=> v10_r)
    else $error("item lost during stall");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import sscp_pkg::*;

  typedef logic signed [127:0] wide_t;

  // one segment pair: first start, first end, second start, second end (x, y, z each)
  typedef struct {
    int c [12];
  } seg_pair_t;

  typedef struct {
    logic [PARAM_W-1:0] s;
    logic [PARAM_W-1:0] t;
    int                 n1 [3];
    int                 n2 [3];
    logic [GAP_W-1:0]   gap;
  } closest_t;

  // Tracks the closest-point results owed by the block and checks each one on arrival.
  class closest_point_tracker;
    closest_t   pending_results[$];
    logic [31:0] threshold = THR_RESET;
    int          mismatches = 0;

    function longint dot3(longint u[3], longint v[3]);
      wide_t acc;
      acc = wide_t'(u[0]) * wide_t'(v[0]) + wide_t'(u[1]) * wide_t'(v[1])
          + wide_t'(u[2]) * wide_t'(v[2]);
      return longint'(acc >>> COORD_W'(16));
    endfunction

    function longint ratio(wide_t num, wide_t den);
      if (num <= 0) return 0;
      if (num >= den) return longint'(PARAM_ONE);
      return longint'((num <<< 16) / den);
    endfunction

    function longint root(wide_t v);
      longint r, cand;
      r = 0;
      for (int b = 34; b >= 0; b--) begin
        cand = r | (longint'(1) << b);
        if (wide_t'(cand) * wide_t'(cand) <= v) r = cand;
      end
      return r;
    endfunction

    function void note(seg_pair_t p);
      longint p0[3], q0[3], d1[3], d2[3], rr[3], c1[3], c2[3];
      longint a, e, f, c, b, thr, s, t, g;
      wide_t denom, tnum, tden, sum;
      closest_t x;
      for (int i = 0; i < 3; i++) begin
        p0[i] = p.c[i];
        q0[i] = p.c[6+i];
        d1[i] = longint'(p.c[3+i]) - p0[i];
        d2[i] = longint'(p.c[9+i]) - q0[i];
        rr[i] = p0[i] - q0[i];
      end
      thr = longint'({32'd0, threshold});
      a = dot3(d1, d1);
      e = dot3(d2, d2);
      f = dot3(d2, rr);
      c = dot3(d1, rr);
      b = dot3(d1, d2);
      s = 0;
      t = 0;
      if (a <= thr && e <= thr) begin
        s = 0;
      end else if (a <= thr) begin
        t = ratio(wide_t'(f), wide_t'(e));
      end else if (e <= thr) begin
        s = ratio(wide_t'(-c), wide_t'(a));
      end else begin
        denom = wide_t'(a) * wide_t'(e) - wide_t'(b) * wide_t'(b);
        // near-parallel: leave s at zero
        if (denom > wide_t'(thr))
          s = ratio(wide_t'(b) * wide_t'(f) - wide_t'(c) * wide_t'(e), denom);
        tnum = wide_t'(b) * wide_t'(s) + (wide_t'(f) <<< 16);
        tden = wide_t'(e) <<< 16;
        if (tnum < 0) begin
          t = 0;
          s = ratio(wide_t'(-c), wide_t'(a));
        end else if (tnum > tden) begin
          t = longint'(PARAM_ONE);
          s = ratio(wide_t'(b - c), wide_t'(a));
        end else begin
          t = ratio(tnum, tden);
        end
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        c1[i] = p0[i] + ((d1[i] * s) >>> 16);
        c2[i] = q0[i] + ((d2[i] * t) >>> 16);
        g = c1[i] - c2[i];
        sum += wide_t'(g) * wide_t'(g);
        x.n1[i] = int'(c1[i]);
        x.n2[i] = int'(c2[i]);
      end
      x.s = s[PARAM_W-1:0];
      x.t = t[PARAM_W-1:0];
      x.gap = GAP_W'(root(sum));
      pending_results.push_back(x);
    endfunction

    function void field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check(closest_t got);
      closest_t w;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding");
        mismatches++;
        return;
      end
      w = pending_results.pop_front();
      field("param_first", w.s, got.s);
      field("param_second", w.t, got.t);
      field("near_first_x", w.n1[0], got.n1[0]);
      field("near_first_y", w.n1[1], got.n1[1]);
      field("near_first_z", w.n1[2], got.n1[2]);
      field("near_second_x", w.n2[0], got.n2[0]);
      field("near_second_y", w.n2[1], got.n2[1]);
      field("near_second_z", w.n2[2], got.n2[2]);
      field("gap_length", w.gap, got.gap);
    endfunction
  endclass

  localparam int U = 65536;
  localparam int MINC = 32'sh8000_0000;
  localparam int MAXC = 2147483647;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;   // idle stretch after the last result is checked

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  seg_pair_t cur;
  logic [PARAM_W-1:0] out_param_first, out_param_second;
  logic signed [COORD_W-1:0] out_near_first_x, out_near_first_y, out_near_first_z;
  logic signed [COORD_W-1:0] out_near_second_x, out_near_second_y, out_near_second_z;
  logic [GAP_W-1:0] out_gap_length;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // quiet: no idling on either side; hold_req: ask the receiver for one long hold-off
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  closest_point_tracker tracker = new();

  initial begin
    for (int i = 0; i < 12; i++) cur.c[i] = 0;
  end

  always #1 clk = ~clk;

  segment_segment_closest_points i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_start_x(cur.c[0]), .in_first_start_y(cur.c[1]), .in_first_start_z(cur.c[2]),
    .in_first_end_x(cur.c[3]), .in_first_end_y(cur.c[4]), .in_first_end_z(cur.c[5]),
    .in_second_start_x(cur.c[6]), .in_second_start_y(cur.c[7]),
    .in_second_start_z(cur.c[8]),
    .in_second_end_x(cur.c[9]), .in_second_end_y(cur.c[10]), .in_second_end_z(cur.c[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_param_first(out_param_first), .out_param_second(out_param_second),
    .out_near_first_x(out_near_first_x), .out_near_first_y(out_near_first_y),
    .out_near_first_z(out_near_first_z),
    .out_near_second_x(out_near_second_x), .out_near_second_y(out_near_second_y),
    .out_near_second_z(out_near_second_z),
    .out_gap_length(out_gap_length),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Sample both channels at the rising edge; inputs only move at the falling edge.
  always @(posedge clk) begin
    closest_t got;
    if (rst_n && in_valid && !in_stall) tracker.note(cur);
    if (rst_n && out_valid && !out_stall) begin
      got.s = out_param_first;
      got.t = out_param_second;
      got.n1[0] = out_near_first_x;
      got.n1[1] = out_near_first_y;
      got.n1[2] = out_near_first_z;
      got.n2[0] = out_near_second_x;
      got.n2[1] = out_near_second_y;
      got.n2[2] = out_near_second_z;
      got.gap = out_gap_length;
      tracker.check(got);
    end
  end

  // Watchdog: count cycles in which no transfer happens on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Offer one pair and hold it until the transfer; may idle first.
  task automatic send_pair(seg_pair_t p);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cur <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_threshold(logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(REG_THRESHOLD) << 2;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracker.threshold = value;
  endtask

  function automatic int coord(int sh);
    return int'($urandom) >>> sh;
  endfunction

  // Random pair: mostly moderate, well-formed geometry; some full range and degenerate.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind, sh, k;
    kind = $urandom_range(0, 9);
    sh = (kind < 2) ? 0 : $urandom_range(4, 20);
    for (int i = 0; i < 12; i++) p.c[i] = coord(sh);
    case (kind)
      6: begin
        for (int i = 0; i < 3; i++) p.c[3+i] = p.c[i] + $urandom_range(0, 1);
      end
      7: begin
        for (int i = 0; i < 3; i++) p.c[9+i] = p.c[6+i] + $urandom_range(0, 1);
      end
      8: begin
        // second segment is a scaled copy of the first direction
        k = $urandom_range(0, 3) - 1;
        for (int i = 0; i < 3; i++) p.c[9+i] = p.c[6+i] + k * (p.c[3+i] - p.c[i]);
      end
      9: begin
        for (int i = 0; i < 3; i++) begin
          p.c[3+i] = p.c[i];
          p.c[9+i] = p.c[6+i];
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_pair(random_pair());
  endtask

  initial begin
    seg_pair_t d [12];
    d[0].c  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    d[1].c  = '{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC};
    d[2].c  = '{MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, MINC};
    d[3].c  = '{MINC, 0, 0, MAXC, 0, 0, 0, MAXC, 0, 0, MINC, 0};
    d[4].c  = '{0, 0, 0, 0, 0, 0, -U, U, 0, U, U, 0};
    d[5].c  = '{-U, U, 0, U, U, 0, 0, 0, 0, 0, 0, 0};
    d[6].c  = '{0, 0, 0, 4*U, 0, 0, 0, U, 0, 4*U, U, 0};
    d[7].c  = '{-2*U, 0, 0, 2*U, 0, 0, 0, -2*U, U, 0, 2*U, U};
    d[8].c  = '{0, 0, 0, 4*U, 0, 0, 2*U, U, 0, 2*U, 5*U, 0};
    d[9].c  = '{0, 0, 0, 4*U, 0, 0, 2*U, -5*U, 0, 2*U, -U, 0};
    d[10].c = '{0, 0, 0, 4*U, 0, 0, 2*U, -4*U, U, 2*U, 0, U};
    d[11].c = '{0, 0, 0, U, 0, 0, 5*U, -U, 0, 5*U, U, 0};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // threshold at its reset value
    foreach (d[i]) send_pair(d[i]);
    random_phase(150);
    drain();

    // exact zero only
    write_threshold(32'd0);
    foreach (d[i]) send_pair(d[i]);
    random_phase(200);
    drain();

    // widest threshold; the receiver holds off long enough to back up the input
    write_threshold(32'hFFFF_FFFF);
    hold_req = 1'b1;
    foreach (d[i]) send_pair(d[i]);
    random_phase(200);
    drain();

    write_threshold($urandom);
    random_phase(200);
    drain();

    // back to the reset value, last stretch with no idling
    write_threshold(THR_RESET);
    random_phase(100);
    quiet = 1'b1;
    random_phase(150);
    drain();

    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
